// ===== sv/schedule_table_time_matcher_unit_assert.svh =====
// Assertion macros for the schedule table time matcher
`ifndef SCHEDULE_TABLE_TIME_MATCHER_UNIT_ASSERT_SVH
`define SCHEDULE_TABLE_TIME_MATCHER_UNIT_ASSERT_SVH

// Clocked assertion, disabled while reset is low
`define STTM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be true at a clock edge
`define STTM_ASSERT_NEVER(name, cond, msg) \
  `STTM_ASSERT(name, !(cond), msg)

`endif

// ===== sv/sttm_pkg.sv =====
// Types and constants shared by the schedule table time matcher
package sttm_pkg;

  localparam int unsigned EntriesDef   = 16;
  localparam int unsigned MaxValuesDef = 10;
  localparam int unsigned Fields       = 4;
  localparam int unsigned ResultCap    = 16;
  localparam int unsigned KindW        = 2;
  localparam int unsigned LenW         = 4;
  localparam int unsigned ValW         = 6;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_RANGE  = 2'd1,
    KIND_LIST   = 2'd2,
    KIND_ANY    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REQ_SET_KIND   = 2'd0,
    REQ_WRITE_SLOT = 2'd1,
    REQ_TICK       = 2'd2,
    REQ_INVALIDATE = 2'd3
  } req_e;

  // Header of one schedule field as kept in a table row
  typedef struct packed {
    kind_e            kind;
    logic [LenW-1:0]  len;
  } fld_hdr_t;

endpackage

// ===== sv/sttm_row_ram.sv =====
// Entry table RAM: one row per schedule entry, registered read
module sttm_row_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4,
  parameter int unsigned Width = 256
) (
  input  logic             clk_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/sttm_field_match.sv =====
// Compare one time field against one schedule field of a table row
module sttm_field_match #(
  parameter int unsigned MaxValues = 10
) (
  input  sttm_pkg::fld_hdr_t                       hdr_i,
  input  logic [MaxValues*sttm_pkg::ValW-1:0]      vals_i,
  input  logic [sttm_pkg::ValW-1:0]                time_i,
  output logic                                     match_o
);
  import sttm_pkg::*;

  logic [ValW-1:0] v0;
  logic [ValW-1:0] v1;
  logic            list_hit;

  assign v0 = vals_i[0 +: ValW];
  assign v1 = vals_i[ValW +: ValW];

  always_comb begin
    list_hit = 1'b0;
    for (int p = 0; p < MaxValues; p++) begin
      if ((5'(p) < {1'b0, hdr_i.len}) && (vals_i[p*ValW +: ValW] == time_i)) begin
        list_hit = 1'b1;
      end
    end
  end

  always_comb begin
    case (hdr_i.kind)
      KIND_SINGLE: match_o = (time_i == v0);
      KIND_RANGE:  match_o = (time_i >= v0) && (time_i <= v1);
      KIND_LIST:   match_o = list_hit;
      KIND_ANY:    match_o = 1'b1;
      default:     match_o = 1'b0;
    endcase
  end

endmodule

// ===== sv/schedule_table_time_matcher_unit.sv =====
// Schedule table time matcher: top level with entry table and scan sequencer
//
// Each schedule entry lives in one row of a single-port-read table RAM that holds all
// four fields (kind, list count, value slots). A load reads the row at the accepting edge,
// then merges the field and writes the row back in the write state; invalidate and
// out-of-range loads complete without leaving idle. A tick scans the table one row per
// cycle: row 0 is read at the accepting edge, then one row is matched per cycle, the
// flush state issues the held result, and it passes through the result register to
// the ports. Results appear on strobe_o for exactly one cycle each, in entry order, one
// per matching valid entry (at most 16), the final one with last_o set; a tick with no
// match gives one result with hit_o low. The receiver cannot stall results. busy drops
// in the cycle in which the final result is on the ports, so the next transaction can
// be accepted at the edge that takes the final result. The table contents are
// undefined after reset; only the valid bits are cleared, so no clearing pass runs.
`include "schedule_table_time_matcher_unit_assert.svh"

module schedule_table_time_matcher_unit #(
  parameter int unsigned Entries   = sttm_pkg::EntriesDef,
  parameter int unsigned MaxValues = sttm_pkg::MaxValuesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 req_type_i,
  input  logic [3:0]                 entry_index_i,
  input  logic [1:0]                 field_select_i,
  input  logic [sttm_pkg::KindW-1:0] field_kind_i,
  input  logic [sttm_pkg::LenW-1:0]  list_length_i,
  input  logic [3:0]                 slot_index_i,
  input  logic [sttm_pkg::ValW-1:0]  slot_value_i,
  input  logic [5:0]                 now_minute_i,
  input  logic [4:0]                 now_hour_i,
  input  logic [4:0]                 now_day_i,
  input  logic [3:0]                 now_month_i,
  output logic                       strobe_o,
  output logic                       hit_o,
  output logic [3:0]                 matched_entry_o,
  output logic                       last_o
);
  import sttm_pkg::*;

  localparam int unsigned AddrW  = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned FieldW = KindW + LenW + ValW * MaxValues;
  localparam int unsigned RowW   = Fields * FieldW;
  localparam int unsigned CntW   = $clog2(ResultCap);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StWrite = 2'd1;
  localparam logic [1:0] StScan  = 2'd2;
  localparam logic [1:0] StFlush = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [Entries-1:0]  valid_q, valid_d;
  logic [AddrW-1:0]    idx_q, idx_d;
  logic                pend_q, pend_d;
  logic [AddrW-1:0]    pend_idx_q, pend_idx_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                strobe_q, strobe_d;
  logic                hit_q, hit_d;
  logic [3:0]          ment_q, ment_d;
  logic                last_q, last_d;

  req_e                req_q;
  logic [1:0]          fsel_q;
  kind_e               kind_q;
  logic [LenW-1:0]     len_q;
  logic [3:0]          slot_q;
  logic [ValW-1:0]     sval_q;
  logic [ValW-1:0]     now_q [Fields];

  logic                accept;
  req_e                req_in;
  logic [6:0]          ent_ext;
  logic                ent_ok;
  logic [AddrW-1:0]    ent_addr;
  logic                slot_ok;
  logic [LenW-1:0]     len_sat;
  logic [AddrW-1:0]    rd_addr;
  logic [RowW-1:0]     rd_row;
  logic [RowW-1:0]     wr_row;
  logic                wr_en;
  logic [Fields-1:0]   fld_match;
  logic                entry_match;
  logic [7:0]          pend_ext;

  assign accept   = start && !busy;
  assign busy     = (state_q != StIdle);
  assign req_in   = req_e'(req_type_i);
  assign ent_ext  = 7'(entry_index_i);
  assign ent_ok   = (ent_ext < 7'(Entries));
  assign ent_addr = ent_ext[AddrW-1:0];
  assign slot_ok  = ({1'b0, slot_index_i} < 5'(MaxValues));
  assign len_sat  = ({1'b0, list_length_i} > 5'(MaxValues)) ? LenW'(MaxValues)
                                                            : list_length_i;
  assign pend_ext = 8'(pend_idx_q);

  // Read the next row while scanning, else the row addressed by the new transaction
  always_comb begin
    if (state_q == StScan) begin
      rd_addr = idx_q + AddrW'(1);
    end else if (req_in == REQ_TICK) begin
      rd_addr = '0;
    end else begin
      rd_addr = ent_addr;
    end
  end

  sttm_row_ram #(
    .Depth (Entries),
    .AddrW (AddrW),
    .Width (RowW)
  ) u_row_ram (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_row),
    .wr_en_i   (wr_en),
    .wr_addr_i (idx_q),
    .wr_data_i (wr_row)
  );

  // Merge the loaded field or slot into the row read back
  always_comb begin
    wr_row = rd_row;
    for (int f = 0; f < Fields; f++) begin
      if (fsel_q == 2'(f)) begin
        if (req_q == REQ_SET_KIND) begin
          wr_row[f*FieldW +: KindW]        = kind_q;
          wr_row[f*FieldW + KindW +: LenW] = len_q;
        end else begin
          for (int p = 0; p < MaxValues; p++) begin
            if (slot_q == 4'(p)) begin
              wr_row[f*FieldW + KindW + LenW + p*ValW +: ValW] = sval_q;
            end
          end
        end
      end
    end
  end

  assign wr_en = (state_q == StWrite);

  for (genvar f = 0; f < Fields; f++) begin : g_field
    fld_hdr_t hdr;
    assign hdr.kind = kind_e'(rd_row[f*FieldW +: KindW]);
    assign hdr.len  = rd_row[f*FieldW + KindW +: LenW];

    sttm_field_match #(
      .MaxValues (MaxValues)
    ) u_match (
      .hdr_i   (hdr),
      .vals_i  (rd_row[f*FieldW + KindW + LenW +: ValW*MaxValues]),
      .time_i  (now_q[f]),
      .match_o (fld_match[f])
    );
  end

  assign entry_match = (&fld_match) && valid_q[idx_q];

  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    idx_d      = idx_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    cnt_d      = cnt_q;
    strobe_d   = 1'b0;
    hit_d      = 1'b0;
    ment_d     = '0;
    last_d     = 1'b0;

    case (state_q)
      StIdle: begin
        if (accept) begin
          case (req_in)
            REQ_SET_KIND: begin
              if (ent_ok) begin
                valid_d[ent_addr] = 1'b1;
                idx_d             = ent_addr;
                state_d           = StWrite;
              end
            end
            REQ_WRITE_SLOT: begin
              if (ent_ok && slot_ok) begin
                idx_d   = ent_addr;
                state_d = StWrite;
              end
            end
            REQ_TICK: begin
              idx_d   = '0;
              pend_d  = 1'b0;
              cnt_d   = '0;
              state_d = StScan;
            end
            REQ_INVALIDATE: begin
              if (ent_ok) begin
                valid_d[ent_addr] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StWrite: begin
        state_d = StIdle;
      end
      StScan: begin
        // Hold each hit back until the next one shows whether it is the final one
        if (entry_match) begin
          if (pend_q) begin
            strobe_d = 1'b1;
            hit_d    = 1'b1;
            ment_d   = pend_ext[3:0];
            cnt_d    = cnt_q + CntW'(1);
          end
          pend_d     = 1'b1;
          pend_idx_d = idx_q;
        end
        if ((entry_match && pend_q && (cnt_q == CntW'(ResultCap - 2))) ||
            (idx_q == AddrW'(Entries - 1))) begin
          state_d = StFlush;
        end else begin
          idx_d = idx_q + AddrW'(1);
        end
      end
      StFlush: begin
        strobe_d = 1'b1;
        hit_d    = pend_q;
        ment_d   = pend_q ? pend_ext[3:0] : 4'd0;
        last_d   = 1'b1;
        pend_d   = 1'b0;
        cnt_d    = '0;
        state_d  = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      valid_q  <= '0;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      idx_q    <= idx_d;
      pend_q   <= pend_d;
      cnt_q    <= cnt_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    hit_q      <= hit_d;
    ment_q     <= ment_d;
    last_q     <= last_d;
    if (accept) begin
      req_q    <= req_in;
      fsel_q   <= field_select_i;
      kind_q   <= kind_e'(field_kind_i);
      len_q    <= len_sat;
      slot_q   <= slot_index_i;
      sval_q   <= slot_value_i;
      now_q[0] <= now_minute_i;
      now_q[1] <= ValW'(now_hour_i);
      now_q[2] <= ValW'(now_day_i);
      now_q[3] <= ValW'(now_month_i);
    end
  end

  assign strobe_o        = strobe_q;
  assign hit_o           = hit_q;
  assign matched_entry_o = ment_q;
  assign last_o          = last_q;

  `STTM_ASSERT(a_nohit_is_last, (strobe_q && !hit_q) |-> last_q, "no-hit result not final")
  `STTM_ASSERT(a_nohit_entry_zero, (strobe_q && !hit_q) |-> (ment_q == 4'd0),
               "no-hit result carries an entry index")
  `STTM_ASSERT_NEVER(a_no_result_in_write, (state_q == StWrite) && strobe_q,
                     "result issued during a row write back")
  `STTM_ASSERT(a_flush_ends_tick, (state_q == StFlush) |=> (strobe_q && last_q && !busy),
               "flush did not issue the final result")
  `STTM_ASSERT(a_scan_count_bound, (state_q == StScan) |-> (cnt_q < CntW'(ResultCap - 1)),
               "scan continued past the result cap")

endmodule
